FILE: hdl/lru_frame_replacer_top_defines.svh
// Assertion macros shared by the LRU frame replacer RTL.
`ifndef LRU_FRAME_REPLACER_TOP_DEFINES_SVH
`define LRU_FRAME_REPLACER_TOP_DEFINES_SVH

// Same-cycle implication, sampled on clock, disabled while reset is high.
`define LFR_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("lru_frame_replacer assertion failed");

// Next-cycle implication, sampled on clock, disabled while reset is high.
`define LFR_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("lru_frame_replacer assertion failed");

`endif

FILE: hdl/lfr_pkg.sv
// Package for the LRU frame replacer: defaults, command codes and states.
`default_nettype none

package lfr_pkg;

   localparam int LFR_NUM_FRAMES = 64;

   typedef enum logic [1:0] {
      CMD_VICTIM = 2'd0,
      CMD_PIN    = 2'd1,
      CMD_UNPIN  = 2'd2
   } lfr_cmd_type;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_EXEC
   } lfr_state_type;

endpackage

`default_nettype wire

FILE: hdl/lfr_ram.sv
// Generic single-write, single-read RAM with a registered read port.
`default_nettype none

module lfr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64,
   localparam int ADDR_W = $clog2(DEPTH)
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]  wr_data,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output logic      [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

`default_nettype wire

FILE: hdl/lru_frame_replacer_top.sv
// LRU frame replacer: doubly linked list of evictable frames kept in RAM.
//
// Requests enter on start with req_cmd and req_frame; one is taken at a
// clock edge where start is high and busy is low. Commands: take victim,
// pin frame, unpin frame. Every request produces exactly one result,
// shown for one cycle with rsp_strobe high; the receiver cannot stall it.
//
// In the accept cycle the listed, next-link and prev-link RAMs are read
// at the target frame (the oldest frame for a victim request); in the
// EXEC state that follows, the list is updated and at most one entry per
// RAM is written. The result is strobed in the cycle after EXEC, as
// rsp_strobe is registered; busy is already low in that cycle, so a new
// request can be taken while a result is shown, but not while one is
// still in EXEC.
//
// After reset the membership RAM is swept clear, one frame per cycle, from
// frame 0 to NUM_FRAMES-1, with busy high during the sweep. The link RAMs
// are never cleared, since a link is only read after it has been written.
`default_nettype none
`include "lru_frame_replacer_top_defines.svh"

module lru_frame_replacer_top
   import lfr_pkg::*;
#(
   parameter int NUM_FRAMES = LFR_NUM_FRAMES,
   localparam int FRAME_W = $clog2(NUM_FRAMES),
   localparam int COUNT_W = $clog2(NUM_FRAMES + 1)
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   output logic                    busy,
   input  wire logic [1:0]         req_cmd,
   input  wire logic [FRAME_W-1:0] req_frame,
   output logic                    rsp_strobe,
   output logic                    rsp_victim_found,
   output logic      [FRAME_W-1:0] rsp_victim_frame,
   output logic      [COUNT_W-1:0] rsp_evictable_count
);

   lfr_state_type state_ff, state_in;
   lfr_cmd_type   cmd_ff, cmd_in;
   logic [FRAME_W-1:0] addr_ff, addr_in;
   logic               frame_ok_ff, frame_ok_in;
   logic [FRAME_W-1:0] oldest_ff, oldest_in;
   logic [FRAME_W-1:0] newest_ff, newest_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic [FRAME_W-1:0] clr_addr_ff, clr_addr_in;
   logic               strobe_ff, strobe_in;
   logic               found_ff, found_in;
   logic [FRAME_W-1:0] vframe_ff, vframe_in;

   logic               accept;
   logic [FRAME_W-1:0] rd_addr;
   logic               unlink_go, append_go;

   logic               lst_we, lst_wd;
   logic [FRAME_W-1:0] lst_wa;
   logic               lst_rd;
   logic               nxt_we, prv_we;
   logic [FRAME_W-1:0] nxt_wa, nxt_wd, nxt_rd;
   logic [FRAME_W-1:0] prv_wa, prv_wd, prv_rd;

   assign busy   = (state_ff != ST_IDLE);
   assign accept = start && !busy;

   // A victim request works on the current oldest frame.
   assign rd_addr = (req_cmd == CMD_VICTIM) ? oldest_ff : req_frame;

   lfr_ram #(.WIDTH(1), .DEPTH(NUM_FRAMES)) u_listed_ram (
      .clock   (clock),
      .wr_en   (lst_we),
      .wr_addr (lst_wa),
      .wr_data (lst_wd),
      .rd_addr (rd_addr),
      .rd_data (lst_rd)
   );

   lfr_ram #(.WIDTH(FRAME_W), .DEPTH(NUM_FRAMES)) u_next_ram (
      .clock   (clock),
      .wr_en   (nxt_we),
      .wr_addr (nxt_wa),
      .wr_data (nxt_wd),
      .rd_addr (rd_addr),
      .rd_data (nxt_rd)
   );

   lfr_ram #(.WIDTH(FRAME_W), .DEPTH(NUM_FRAMES)) u_prev_ram (
      .clock   (clock),
      .wr_en   (prv_we),
      .wr_addr (prv_wa),
      .wr_data (prv_wd),
      .rd_addr (rd_addr),
      .rd_data (prv_rd)
   );

   assign unlink_go = (state_ff == ST_EXEC) &&
                      (((cmd_ff == CMD_VICTIM) && (count_ff != '0)) ||
                       ((cmd_ff == CMD_PIN) && frame_ok_ff && lst_rd));
   assign append_go = (state_ff == ST_EXEC) &&
                      (cmd_ff == CMD_UNPIN) && frame_ok_ff && !lst_rd;

   always_comb begin
      state_in    = state_ff;
      cmd_in      = cmd_ff;
      addr_in     = addr_ff;
      frame_ok_in = frame_ok_ff;
      oldest_in   = oldest_ff;
      newest_in   = newest_ff;
      count_in    = count_ff;
      clr_addr_in = clr_addr_ff;
      strobe_in   = 1'b0;
      found_in    = found_ff;
      vframe_in   = vframe_ff;
      lst_we      = 1'b0;
      lst_wa      = addr_ff;
      lst_wd      = 1'b0;
      nxt_we      = 1'b0;
      nxt_wa      = prv_rd;
      nxt_wd      = nxt_rd;
      prv_we      = 1'b0;
      prv_wa      = nxt_rd;
      prv_wd      = prv_rd;

      case (state_ff)
         ST_CLEAR: begin
            lst_we      = 1'b1;
            lst_wa      = clr_addr_ff;
            clr_addr_in = clr_addr_ff + FRAME_W'(1);
            if (clr_addr_ff == FRAME_W'(NUM_FRAMES - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               state_in    = ST_EXEC;
               cmd_in      = lfr_cmd_type'(req_cmd);
               addr_in     = rd_addr;
               frame_ok_in = (32'(req_frame) < NUM_FRAMES);
            end
         end
         ST_EXEC: begin
            state_in = ST_IDLE;
            if (unlink_go) begin
               lst_we   = 1'b1;
               count_in = count_ff - COUNT_W'(1);
               if (count_ff <= COUNT_W'(1)) begin
                  oldest_in = '0;
                  newest_in = '0;
               end else if (addr_ff == oldest_ff) begin
                  oldest_in = nxt_rd;
               end else if (addr_ff == newest_ff) begin
                  newest_in = prv_rd;
               end else begin
                  // Bridge the neighbors around the frame leaving the middle.
                  nxt_we = 1'b1;
                  prv_we = 1'b1;
               end
            end else if (append_go) begin
               lst_we   = 1'b1;
               lst_wd   = 1'b1;
               count_in = count_ff + COUNT_W'(1);
               if (count_ff == '0) begin
                  oldest_in = addr_ff;
                  newest_in = addr_ff;
               end else begin
                  nxt_we    = 1'b1;
                  nxt_wa    = newest_ff;
                  nxt_wd    = addr_ff;
                  prv_we    = 1'b1;
                  prv_wa    = addr_ff;
                  prv_wd    = newest_ff;
                  newest_in = addr_ff;
               end
            end
            strobe_in = 1'b1;
            found_in  = (cmd_ff == CMD_VICTIM) && (count_ff != '0);
            vframe_in = found_in ? addr_ff : '0;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_CLEAR;
         oldest_ff   <= '0;
         newest_ff   <= '0;
         count_ff    <= '0;
         clr_addr_ff <= '0;
         strobe_ff   <= 1'b0;
      end else begin
         state_ff    <= state_in;
         oldest_ff   <= oldest_in;
         newest_ff   <= newest_in;
         count_ff    <= count_in;
         clr_addr_ff <= clr_addr_in;
         strobe_ff   <= strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff      <= cmd_in;
      addr_ff     <= addr_in;
      frame_ok_ff <= frame_ok_in;
      found_ff    <= found_in;
      vframe_ff   <= vframe_in;
   end

   assign rsp_strobe          = strobe_ff;
   assign rsp_victim_found    = found_ff;
   assign rsp_victim_frame    = vframe_ff;
   assign rsp_evictable_count = count_ff;

   `LFR_ASSERT_NOW(a_accept_in_idle, accept, state_ff == ST_IDLE)
   `LFR_ASSERT_NEXT(a_exec_gives_result, state_ff == ST_EXEC, rsp_strobe)
   `LFR_ASSERT_NOW(a_empty_ends_zero, count_ff == '0, oldest_ff == '0 && newest_ff == '0)
   `LFR_ASSERT_NOW(a_full_no_append, count_ff == COUNT_W'(NUM_FRAMES), !append_go)
   `LFR_ASSERT_NOW(a_count_in_range, rsp_strobe, rsp_evictable_count <= COUNT_W'(NUM_FRAMES))

endmodule

`default_nettype wire
